@@ hw/rtl/sbk_pkg.sv @@
// shared types and constants for the colour-key sprite blitter
// used by every module of the blitter; depends on nothing

package sbk_pkg;

    localparam int SBK_SCREEN_WIDTH  = 320;
    localparam int SBK_SCREEN_HEIGHT = 200;

    localparam int SBK_CFG_IDX_W  = 3;
    localparam int SBK_CFG_DATA_W = 9;
    localparam int SBK_ADDR_OUT_W = 16;

    // register indexes on the configuration port
    localparam logic [SBK_CFG_IDX_W-1:0] SBK_REG_DEST_X       = 3'd0;
    localparam logic [SBK_CFG_IDX_W-1:0] SBK_REG_DEST_Y       = 3'd1;
    localparam logic [SBK_CFG_IDX_W-1:0] SBK_REG_SPRITE_WIDTH = 3'd2;
    localparam logic [SBK_CFG_IDX_W-1:0] SBK_REG_CLIP_X_START = 3'd3;
    localparam logic [SBK_CFG_IDX_W-1:0] SBK_REG_CLIP_X_STOP  = 3'd4;
    localparam logic [SBK_CFG_IDX_W-1:0] SBK_REG_CLIP_Y_START = 3'd5;
    localparam logic [SBK_CFG_IDX_W-1:0] SBK_REG_CLIP_Y_STOP  = 3'd6;
    localparam logic [SBK_CFG_IDX_W-1:0] SBK_REG_TRANSP_EN    = 3'd7;

    typedef struct packed {
        logic [8:0] dest_x;
        logic [7:0] dest_y;
        logic [8:0] sprite_width;
        logic [8:0] clip_x_start;
        logic [8:0] clip_x_stop;
        logic [7:0] clip_y_start;
        logic [7:0] clip_y_stop;
        logic       transparent_enable;
    } t_sbk_cfg;

    // one classified pixel on its way from the front to the back
    typedef struct packed {
        logic [9:0] sx;
        logic [8:0] sy;
        logic [7:0] pix;
        logic       last;
        logic       draw;
    } t_sbk_item;

    typedef struct packed {
        logic full;
        logic empty;
    } t_sbk_qstat;

endpackage

@@ hw/rtl/sbk_front.sv @@
// front part: sprite column and row counters, screen position, clip and colour-key test
// depends on sbk_pkg

module sbk_front
    import sbk_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_sbk_cfg    i_cfg,
    input  logic        i_accept,
    input  logic [7:0]  i_pixel_value,
    input  logic        i_last_pixel,
    output t_sbk_item   o_item
);

    logic [8:0] r_col;
    logic [7:0] r_row;
    logic [8:0] n_col;
    logic [7:0] n_row;
    logic [9:0] col_inc;
    logic       in_clip;
    logic       opaque;

    always_comb begin
        o_item.sx   = {1'b0, i_cfg.dest_x} + {1'b0, r_col};
        o_item.sy   = {1'b0, i_cfg.dest_y} + {1'b0, r_row};
        o_item.pix  = i_pixel_value;
        o_item.last = i_last_pixel;
        in_clip = (o_item.sx >= {1'b0, i_cfg.clip_x_start})
               && (o_item.sx <= {1'b0, i_cfg.clip_x_stop})
               && (o_item.sy >= {1'b0, i_cfg.clip_y_start})
               && (o_item.sy <= {1'b0, i_cfg.clip_y_stop});
        opaque = !(i_cfg.transparent_enable && (i_pixel_value == 8'd0));
        o_item.draw = in_clip && opaque;
    end

    // advance after every pixel, back to the origin after the last one
    always_comb begin
        col_inc = {1'b0, r_col} + 10'd1;
        n_col   = r_col;
        n_row   = r_row;
        if (i_accept) begin
            if (i_last_pixel) begin
                n_col = '0;
                n_row = '0;
            end else if (col_inc >= {1'b0, i_cfg.sprite_width}) begin
                n_col = '0;
                n_row = r_row + 8'd1;
            end else begin
                n_col = col_inc[8:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

endmodule

@@ hw/rtl/sbk_queue.sv @@
// two-entry queue of classified pixels between the front and the back
// depends on sbk_pkg

module sbk_queue
    import sbk_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_sbk_item  i_item,
    input  logic       i_pop,
    output t_sbk_item  o_item,
    output t_sbk_qstat o_stat
);

    t_sbk_item  r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    assign o_item       = r_mem[r_rd_ptr];
    assign o_stat.full  = (r_count == 2'd2);
    assign o_stat.empty = (r_count == 2'd0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            unique case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

@@ hw/rtl/sbk_back.sv @@
// back part: framebuffer address, frame bound test and output register
// depends on sbk_pkg

module sbk_back
    import sbk_pkg::*;
#(
    parameter int SCREEN_WIDTH  = SBK_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = SBK_SCREEN_HEIGHT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_sbk_item   i_item,
    input  t_sbk_qstat  i_qstat,
    output logic        o_pop,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [15:0] o_write_address,
    output logic [7:0]  o_write_data,
    output logic        o_write_enable,
    output logic        o_sprite_done
);

    localparam int MaxSum  = 511 * SCREEN_WIDTH + 1023;
    localparam int Frame   = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int SumW    = $clog2(MaxSum + 1);
    localparam int FrameW  = $clog2(Frame + 1);
    localparam int CalcW0  = (SumW > FrameW) ? SumW : FrameW;
    localparam int CalcW   = (CalcW0 > SBK_ADDR_OUT_W) ? CalcW0 : SBK_ADDR_OUT_W;

    logic [CalcW-1:0] addr;
    logic             in_frame;
    logic             load;

    logic        r_valid;
    logic [15:0] r_addr;
    logic [7:0]  r_data;
    logic        r_we;
    logic        r_done;

    // constant-width multiply by the screen width, then one add
    always_comb begin
        addr = CalcW'(i_item.sy) * CalcW'(SCREEN_WIDTH) + CalcW'(i_item.sx);
        in_frame = (addr < CalcW'(Frame));
    end

    assign load  = !r_valid || i_ready;
    assign o_pop = load && !i_qstat.empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= !i_qstat.empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_addr <= addr[15:0];
            r_data <= i_item.pix;
            r_we   <= i_item.draw && in_frame;
            r_done <= i_item.last;
        end
    end

    assign o_valid         = r_valid;
    assign o_write_address = r_addr;
    assign o_write_data    = r_data;
    assign o_write_enable  = r_we;
    assign o_sprite_done   = r_done;

endmodule

@@ hw/rtl/sprite_blit_color_key_clip_core.sv @@
// colour-key sprite blitter with inclusive clip rectangle, top level
// path: an accepted pixel goes into the queue, then into the output register when it can load
// throughput: one pixel per clock while the queue has room; once a held output has
// filled the queue, input reopens in the cycle after the output moves
// reset (synchronous, active low) empties the queue and output, zeroes the
// counters and loads the register defaults (full-screen clip, transparency on)

module sprite_blit_color_key_clip_core
    import sbk_pkg::*;
#(
    parameter int SCREEN_WIDTH  = SBK_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = SBK_SCREEN_HEIGHT
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // configuration write channel
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [SBK_CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [SBK_CFG_DATA_W-1:0] i_cfg_data,
    // sprite pixel channel
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic [7:0]                i_pixel_value,
    input  logic                      i_last_pixel,
    // framebuffer write channel
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic [15:0]               o_write_address,
    output logic [7:0]                o_write_data,
    output logic                      o_write_enable,
    output logic                      o_sprite_done
);

    t_sbk_cfg   r_cfg;
    t_sbk_item  front_item;
    t_sbk_item  queue_item;
    t_sbk_qstat qstat;
    logic       in_accept;
    logic       pop;

    // register file: always ready, writes land at once
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dest_x             <= 9'd0;
            r_cfg.dest_y             <= 8'd0;
            r_cfg.sprite_width       <= 9'd1;
            r_cfg.clip_x_start       <= 9'd0;
            r_cfg.clip_x_stop        <= 9'd319;
            r_cfg.clip_y_start       <= 8'd0;
            r_cfg.clip_y_stop        <= 8'd199;
            r_cfg.transparent_enable <= 1'b1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                SBK_REG_DEST_X:       r_cfg.dest_x       <= i_cfg_data[8:0];
                SBK_REG_DEST_Y:       r_cfg.dest_y       <= i_cfg_data[7:0];
                SBK_REG_SPRITE_WIDTH: r_cfg.sprite_width <= i_cfg_data[8:0];
                SBK_REG_CLIP_X_START: r_cfg.clip_x_start <= i_cfg_data[8:0];
                SBK_REG_CLIP_X_STOP:  r_cfg.clip_x_stop  <= i_cfg_data[8:0];
                SBK_REG_CLIP_Y_START: r_cfg.clip_y_start <= i_cfg_data[7:0];
                SBK_REG_CLIP_Y_STOP:  r_cfg.clip_y_stop  <= i_cfg_data[7:0];
                SBK_REG_TRANSP_EN:    r_cfg.transparent_enable <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // front takes a pixel whenever the queue has room
    assign o_in_ready = !qstat.full;
    assign in_accept  = i_in_valid && o_in_ready;

    sbk_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_accept      (in_accept),
        .i_pixel_value (i_pixel_value),
        .i_last_pixel  (i_last_pixel),
        .o_item        (front_item)
    );

    // decouples the counters from output back-pressure
    sbk_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (in_accept),
        .i_item  (front_item),
        .i_pop   (pop),
        .o_item  (queue_item),
        .o_stat  (qstat)
    );

    // address arithmetic and the registered output word
    sbk_back #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_item          (queue_item),
        .i_qstat         (qstat),
        .o_pop           (pop),
        .o_valid         (o_out_valid),
        .i_ready         (i_out_ready),
        .o_write_address (o_write_address),
        .o_write_data    (o_write_data),
        .o_write_enable  (o_write_enable),
        .o_sprite_done   (o_sprite_done)
    );

    // an output word only appears after the queue held something
    a_out_from_queue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(!qstat.empty))
        else $error("output word appeared without a queued pixel");

    // a word taken with the queue empty leaves the output empty
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && qstat.empty) |=> !o_out_valid)
        else $error("output word repeated after draining");

    // a pixel pushed without a pop leaves the queue non-empty
    a_push_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && !pop) |=> !qstat.empty)
        else $error("accepted pixel lost from the queue");

endmodule

@@ test/sbk_write_checker.sv @@
// scoreboard for the colour-key sprite blitter: watches config, pixel and framebuffer channels
// keeps its own register copy and pixel counters, predicts each framebuffer word and compares
// depends on sbk_pkg for register indexes and the register struct

module sbk_write_checker
    import sbk_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_valid,
    input  logic                      i_cfg_ready,
    input  logic [SBK_CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [SBK_CFG_DATA_W-1:0] i_cfg_data,
    input  logic                      i_in_valid,
    input  logic                      i_in_ready,
    input  logic [7:0]                i_pixel_value,
    input  logic                      i_last_pixel,
    input  logic                      i_out_valid,
    input  logic                      i_out_ready,
    input  logic [15:0]               i_write_address,
    input  logic [7:0]                i_write_data,
    input  logic                      i_write_enable,
    input  logic                      i_sprite_done,
    output int                        o_fail_count,
    output int                        o_pending,
    output int                        o_checked,
    output int                        o_drawn
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [15:0] address;
        logic [7:0]  data;
        logic        enable;
        logic        done;
    } t_fb_write;

    t_sbk_cfg    regs;
    logic [8:0]  col;
    logic [7:0]  row;
    t_fb_write   expected_writes[$];

    // place one sprite pixel on screen and step the column and row counters
    function automatic t_fb_write place_pixel(input logic [7:0] pix, input logic last);
        int unsigned sx;
        int unsigned sy;
        int unsigned addr;
        logic [9:0]  next_col;
        t_fb_write   w;
        sx = regs.dest_x + col;
        sy = regs.dest_y + row;
        addr = sy * SBK_SCREEN_WIDTH + sx;
        w.address = addr[15:0];
        w.data    = pix;
        w.enable  = !(regs.transparent_enable && pix == 8'd0)
                    && sx >= regs.clip_x_start && sx <= regs.clip_x_stop
                    && sy >= regs.clip_y_start && sy <= regs.clip_y_stop
                    && addr < SBK_SCREEN_WIDTH * SBK_SCREEN_HEIGHT;
        w.done    = last;
        if (last) begin
            col = '0;
            row = '0;
        end else begin
            next_col = col + 10'd1;
            if (next_col >= regs.sprite_width) begin
                col = '0;
                row = row + 8'd1;
            end else begin
                col = next_col[8:0];
            end
        end
        return w;
    endfunction

    always @(posedge i_clk) begin : watch
        t_fb_write got;
        t_fb_write want;
        if (!i_rst_n) begin
            regs.dest_x             = '0;
            regs.dest_y             = '0;
            regs.sprite_width       = 9'd1;
            regs.clip_x_start       = '0;
            regs.clip_x_stop        = 9'(SBK_SCREEN_WIDTH - 1);
            regs.clip_y_start       = '0;
            regs.clip_y_stop        = 8'(SBK_SCREEN_HEIGHT - 1);
            regs.transparent_enable = 1'b1;
            col = '0;
            row = '0;
            expected_writes.delete();
        end else begin
            // results first: a word accepted now cannot come from a pixel accepted now
            if (i_out_valid && i_out_ready) begin
                got = '{i_write_address, i_write_data, i_write_enable, i_sprite_done};
                o_checked++;
                if (expected_writes.size() == 0) begin
                    $error("framebuffer word with no pixel pending: write_address %0d",
                           got.address);
                    o_fail_count++;
                end else begin
                    want = expected_writes.pop_front();
                    if (want.enable)
                        o_drawn++;
                    if (got.address !== want.address) begin
                        $error("write_address: expected %0d, got %0d", want.address,
                               got.address);
                        o_fail_count++;
                    end
                    if (got.data !== want.data) begin
                        $error("write_data: expected %0d, got %0d", want.data, got.data);
                        o_fail_count++;
                    end
                    if (got.enable !== want.enable) begin
                        $error("write_enable: expected %0b, got %0b", want.enable,
                               got.enable);
                        o_fail_count++;
                    end
                    if (got.done !== want.done) begin
                        $error("sprite_done: expected %0b, got %0b", want.done, got.done);
                        o_fail_count++;
                    end
                end
            end
            if (i_in_valid && i_in_ready)
                expected_writes.push_back(place_pixel(i_pixel_value, i_last_pixel));
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    SBK_REG_DEST_X:       regs.dest_x             = i_cfg_data;
                    SBK_REG_DEST_Y:       regs.dest_y             = i_cfg_data[7:0];
                    SBK_REG_SPRITE_WIDTH: regs.sprite_width       = i_cfg_data;
                    SBK_REG_CLIP_X_START: regs.clip_x_start       = i_cfg_data;
                    SBK_REG_CLIP_X_STOP:  regs.clip_x_stop        = i_cfg_data;
                    SBK_REG_CLIP_Y_START: regs.clip_y_start       = i_cfg_data[7:0];
                    SBK_REG_CLIP_Y_STOP:  regs.clip_y_stop        = i_cfg_data[7:0];
                    SBK_REG_TRANSP_EN:    regs.transparent_enable = i_cfg_data[0];
                    default: ;
                endcase
            end
        end
        o_pending = expected_writes.size();
    end

endmodule

@@ test/sprite_blit_color_key_clip_core_tb.sv @@
// top of the sprite blitter testbench: clock, reset, stimulus, output back-pressure, verdict
// depends on sbk_pkg, the blitter core and sbk_write_checker, which does all the comparing

module sprite_blit_color_key_clip_core_tb
    import sbk_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int BUSY_PCT       = 54;   // idling share when one side idles alone
    localparam int BOTH_PCT       = 27;   // idling share of each side when both idle
    localparam int HOLD_CYCLES    = 300;  // long output hold-off, fills the core's queue
    localparam int WATCHDOG_LIMIT = 3000; // cycles with no word moving on any channel
    localparam int SETTLE_CYCLES  = 4;    // margin after the last predicted word has come out
    localparam int RANDOM_PHASES  = 20;
    localparam int PHASE_PIXELS   = 80;
    localparam int WRAP_PIXELS    = 300;  // more rows than the 8-bit row counter holds

    logic                      i_clk = 1'b0;
    logic                      i_rst_n;
    logic                      i_cfg_valid;
    logic                      o_cfg_ready;
    logic [SBK_CFG_IDX_W-1:0]  i_cfg_index;
    logic [SBK_CFG_DATA_W-1:0] i_cfg_data;
    logic                      i_in_valid;
    logic                      o_in_ready;
    logic [7:0]                i_pixel_value;
    logic                      i_last_pixel;
    logic                      o_out_valid;
    logic                      i_out_ready = 1'b0;
    logic [15:0]               o_write_address;
    logic [7:0]                o_write_data;
    logic                      o_write_enable;
    logic                      o_sprite_done;

    int chk_fail;
    int chk_pending;
    int chk_checked;
    int chk_drawn;

    // idling knobs, changed per phase by the stimulus
    int tx_idle_pct;
    int rx_stall_pct;
    // hold-off requests from the stimulus, served by the receiver process
    int hold_asked;
    int hold_served;
    int hold_left;
    int stall_cycles;
    int settings_seen;
    t_sbk_cfg cur;

    sprite_blit_color_key_clip_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_pixel_value   (i_pixel_value),
        .i_last_pixel    (i_last_pixel),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_write_address (o_write_address),
        .o_write_data    (o_write_data),
        .o_write_enable  (o_write_enable),
        .o_sprite_done   (o_sprite_done)
    );

    sbk_write_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .i_in_ready      (o_in_ready),
        .i_pixel_value   (i_pixel_value),
        .i_last_pixel    (i_last_pixel),
        .i_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .i_write_address (o_write_address),
        .i_write_data    (o_write_data),
        .i_write_enable  (o_write_enable),
        .i_sprite_done   (o_sprite_done),
        .o_fail_count    (chk_fail),
        .o_pending       (chk_pending),
        .o_checked       (chk_checked),
        .o_drawn         (chk_drawn)
    );

    // 4 ns period
    always #2 i_clk = ~i_clk;

    // framebuffer side: random stalls, or a long hold-off when one is asked for
    always @(negedge i_clk) begin
        if (hold_asked != hold_served) begin
            hold_served = hold_asked;
            hold_left   = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // watchdog: any word moving on any channel restarts the count
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
            || (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("sprite_blit_color_key_clip_core verification failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // one register write; leaves valid high so back-to-back writes follow without a gap
    task automatic write_reg(input logic [SBK_CFG_IDX_W-1:0] idx,
                             input logic [SBK_CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
    endtask

    // writes all eight registers; unused upper data bits carry noise the core must drop
    task automatic program_regs(input t_sbk_cfg c);
        write_reg(SBK_REG_DEST_X, c.dest_x);
        write_reg(SBK_REG_DEST_Y, {($urandom_range(1) != 0), c.dest_y});
        write_reg(SBK_REG_SPRITE_WIDTH, c.sprite_width);
        write_reg(SBK_REG_CLIP_X_START, c.clip_x_start);
        write_reg(SBK_REG_CLIP_X_STOP, c.clip_x_stop);
        write_reg(SBK_REG_CLIP_Y_START, {($urandom_range(1) != 0), c.clip_y_start});
        write_reg(SBK_REG_CLIP_Y_STOP, {($urandom_range(1) != 0), c.clip_y_stop});
        write_reg(SBK_REG_TRANSP_EN, {8'($urandom), c.transparent_enable});
        i_cfg_valid <= 1'b0;
        cur = c;
        settings_seen++;
    endtask

    // offer one pixel word, with random gaps before it; returns at the falling edge
    // after acceptance with valid still high, so the next call raises nothing twice
    task automatic send_pixel(input logic [7:0] pix, input logic last);
        while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_pixel_value <= pix;
        i_last_pixel  <= last;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
    endtask

    // stop offering and wait until every predicted word has come out
    task automatic settle_block();
        i_in_valid <= 1'b0;
        while (chk_pending != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // register settings: wild ones use any bit pattern, tame ones stay on screen
    function automatic t_sbk_cfg pick_settings(input bit wild);
        t_sbk_cfg c;
        int a;
        int b;
        int t;
        bit rare;
        if (wild) begin
            c.dest_x             = 9'($urandom);
            c.dest_y             = 8'($urandom);
            c.sprite_width       = 9'($urandom);
            c.clip_x_start       = 9'($urandom);
            c.clip_x_stop        = 9'($urandom);
            c.clip_y_start       = 8'($urandom);
            c.clip_y_stop        = 8'($urandom);
            c.transparent_enable = 1'($urandom);
            return c;
        end
        if ($urandom_range(2) == 0) begin
            // full-screen window
            c.clip_x_start = '0;
            c.clip_x_stop  = 9'(SBK_SCREEN_WIDTH - 1);
            c.clip_y_start = '0;
            c.clip_y_stop  = 8'(SBK_SCREEN_HEIGHT - 1);
        end else begin
            // ordered window, now and then turned inside out so nothing draws
            rare = ($urandom_range(7) == 0);
            a = $urandom_range(SBK_SCREEN_WIDTH - 1);
            b = $urandom_range(SBK_SCREEN_WIDTH - 1);
            if ((a > b) != rare) begin
                t = a; a = b; b = t;
            end
            c.clip_x_start = 9'(a);
            c.clip_x_stop  = 9'(b);
            a = $urandom_range(SBK_SCREEN_HEIGHT - 1);
            b = $urandom_range(SBK_SCREEN_HEIGHT - 1);
            if ((a > b) != rare) begin
                t = a; a = b; b = t;
            end
            c.clip_y_start = 8'(a);
            c.clip_y_stop  = 8'(b);
        end
        // half the sprites straddle the window's top-left edge
        if ($urandom_range(1) == 0) begin
            c.dest_x = (c.clip_x_start > 3) ? c.clip_x_start - 9'd3 : '0;
            c.dest_y = (c.clip_y_start > 2) ? c.clip_y_start - 8'd2 : '0;
        end else begin
            c.dest_x = 9'($urandom_range(SBK_SCREEN_WIDTH - 1));
            c.dest_y = 8'($urandom_range(SBK_SCREEN_HEIGHT - 1));
        end
        case ($urandom_range(9))
            6, 7:    c.sprite_width = 9'($urandom_range(80, 13));
            8:       c.sprite_width = 9'(SBK_SCREEN_WIDTH);
            9:       c.sprite_width = '0;
            default: c.sprite_width = 9'($urandom_range(12, 1));
        endcase
        c.transparent_enable = 1'($urandom);
        return c;
    endfunction

    // a run of sprites of random height; the budget may cut the last one short,
    // and some sprites lose their end marker or get a stray one inside
    task automatic blit_phase(input int budget);
        int eff_w;
        int npix;
        bit end_mark;
        while (budget > 0) begin
            eff_w = (cur.sprite_width == 0) ? 1 : int'(cur.sprite_width);
            npix  = eff_w * $urandom_range(5, 1);
            if (npix > budget)
                npix = budget;
            end_mark = ($urandom_range(7) != 0);
            for (int k = 0; k < npix; k++) begin
                send_pixel(($urandom_range(3) == 0) ? 8'd0 : 8'($urandom),
                           (k == npix - 1) ? end_mark : ($urandom_range(63) == 0));
            end
            budget -= npix;
        end
    endtask

    initial begin : stimulus
        t_sbk_cfg wrap_cfg;
        // every input known from time zero
        i_rst_n       = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        i_in_valid    = 1'b0;
        i_pixel_value = '0;
        i_last_pixel  = 1'b0;
        tx_idle_pct   = 0;
        rx_stall_pct  = 0;
        hold_asked    = 0;
        settings_seen = 1;
        cur = '{dest_x: '0, dest_y: '0, sprite_width: 9'd1, clip_x_start: '0,
                clip_x_stop: 9'd319, clip_y_start: '0, clip_y_stop: 8'd199,
                transparent_enable: 1'b1};

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset defaults: one-pixel-wide sprite, transparency on, full-screen clip
        send_pixel(8'h00, 1'b0);
        send_pixel(8'hFF, 1'b0);
        send_pixel(8'h01, 1'b0);
        send_pixel(8'h80, 1'b1);
        settle_block();

        // bottom-right corner, opaque: right columns clipped, third row off the frame
        program_regs('{dest_x: 9'd318, dest_y: 8'd198, sprite_width: 9'd4,
                       clip_x_start: 9'd0, clip_x_stop: 9'd319, clip_y_start: 8'd0,
                       clip_y_stop: 8'd199, transparent_enable: 1'b0});
        for (int k = 0; k < 9; k++)
            send_pixel(8'(k * 85), k == 8);
        settle_block();

        // all-ones position, zero width, inside-out window: nothing drawn, address wraps
        program_regs('{dest_x: 9'd511, dest_y: 8'd255, sprite_width: 9'd0,
                       clip_x_start: 9'd319, clip_x_stop: 9'd0, clip_y_start: 8'd199,
                       clip_y_stop: 8'd0, transparent_enable: 1'b1});
        send_pixel(8'h00, 1'b0);
        send_pixel(8'h01, 1'b0);
        send_pixel(8'h80, 1'b1);
        settle_block();

        // narrow window, inclusive edges: only columns 1 and 2 of row 1 draw
        program_regs('{dest_x: 9'd0, dest_y: 8'd0, sprite_width: 9'd4,
                       clip_x_start: 9'd1, clip_x_stop: 9'd2, clip_y_start: 8'd1,
                       clip_y_stop: 8'd1, transparent_enable: 1'b0});
        for (int k = 0; k < 8; k++)
            send_pixel((k == 5) ? 8'd0 : 8'(k * 31 + 1), k == 7);
        settle_block();

        // random phases cycling through the idling patterns
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            program_regs(pick_settings(ph % 5 == 4));
            case (ph % 4)
                0:       begin tx_idle_pct = 0;        rx_stall_pct = 0;        end
                1:       begin tx_idle_pct = BUSY_PCT; rx_stall_pct = 0;        end
                2:       begin tx_idle_pct = 0;        rx_stall_pct = BUSY_PCT; end
                default: begin tx_idle_pct = BOTH_PCT; rx_stall_pct = BOTH_PCT; end
            endcase
            // sender keeps offering while the output is held back
            if (ph == 4)
                hold_asked++;
            if (ph == 9) begin
                blit_phase(PHASE_PIXELS / 2);
                settle_block();
                blit_phase(PHASE_PIXELS / 2);
            end else begin
                blit_phase(PHASE_PIXELS);
            end
            settle_block();
        end

        // zero width makes every pixel a new row, so the row counter wraps
        wrap_cfg = pick_settings(1'b0);
        wrap_cfg.sprite_width = '0;
        program_regs(wrap_cfg);
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        for (int k = 0; k < WRAP_PIXELS; k++)
            send_pixel(($urandom_range(3) == 0) ? 8'd0 : 8'($urandom), k == WRAP_PIXELS - 1);
        settle_block();

        if (chk_pending != 0)
            $error("%0d framebuffer words never arrived", chk_pending);
        $display("%0d pixel words checked, %0d drawn, across %0d register settings",
                 chk_checked, chk_drawn, settings_seen);
        $display("idling patterns, a long output hold-off, a drain pause and a row wrap ran");
        if (chk_fail == 0 && chk_pending == 0) begin
            $display("sprite_blit_color_key_clip_core verification clean");
        end else begin
            $display("sprite_blit_color_key_clip_core verification failed");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/sbk_pkg.sv
hw/rtl/sbk_front.sv
hw/rtl/sbk_queue.sv
hw/rtl/sbk_back.sv
hw/rtl/sprite_blit_color_key_clip_core.sv
test/sbk_write_checker.sv
test/sprite_blit_color_key_clip_core_tb.sv
